// File: design/gif_lzw_decoder_macros.svh
// ----------------------------------------------------------------------------
// GIF LZW decoder assertion macros
// Short forms for the concurrent checks used in the decoder controller.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_DECODER_MACROS_SVH
`define GIF_LZW_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLZW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLZW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/glzw_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Shared constants, a helper function and the controller/datapath link types.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_ENTRIES = 4096;
  localparam int TAB_AW        = 12;
  localparam int DEPTH_W       = 13;
  localparam int SYM_W         = 9;
  localparam int ACC_BITS      = 20;
  localparam int HELD_W        = 5;
  localparam int CNT_W         = 7;

  localparam logic [CNT_W-1:0] RES_MAX      = 7'd64;
  localparam logic [3:0]       MIN_SIZE_RST = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_SIZE = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;
  localparam logic [1:0] REG_INTERLACE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic dec;
    logic walk_rd;
    logic walk_push;
    logic walk_end;
    logic pop_rd;
    logic pop_emit;
    logic flush;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finished;
    logic stack_nz;
    logic bits_ok;
    logic is_clr;
    logic is_end;
    logic is_first;
    logic walk_more;
    logic emit_ok;
    logic pend_v;
    logic acc_status;
  } dp_stat_t;

  // Minimum code size saturated to the legal range 2 to 9.
  function automatic logic [3:0] eff_size(input logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (r < 4'd2) r = 4'd2;
    if (r > 4'd9) r = 4'd9;
    return r;
  endfunction

endpackage

// File: design/glzw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/glzw_ctrl.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder controller
// Sequences byte intake, code decode, chain walks, pixel pops and the flush
// of the held result at the end of each input beat.
// ----------------------------------------------------------------------------
module glzw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  glzw_pkg::dp_stat_t  st,
  output glzw_pkg::ctl_cmd_t  cmd
);
  import glzw_pkg::*;

  `include "gif_lzw_decoder_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOP  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_TRD   = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign data_stall = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (data_valid) begin
          cmd.accept = 1'b1;
          cnt_next   = st.acc_status ? CNT_W'(1) : '0;
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        if (cnt == RES_MAX || st.finished) begin
          state_next = S_FLUSH;
        end else if (st.stack_nz) begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP;
        end else if (!st.bits_ok) begin
          state_next = S_FLUSH;
        end else if (st.is_end) begin
          if (st.emit_ok) begin
            cmd.dec  = 1'b1;
            cnt_next = cnt + CNT_W'(1);
          end
        end else begin
          cmd.dec = 1'b1;
          if (!st.is_clr && !st.is_first) begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (st.walk_more) begin
          cmd.walk_rd = 1'b1;
          state_next  = S_TRD;
        end else begin
          cmd.walk_end = 1'b1;
          state_next   = S_LOOP;
        end
      end
      S_TRD: begin
        cmd.walk_push = 1'b1;
        state_next    = S_WALK;
      end
      S_POP: begin
        if (st.emit_ok) begin
          cmd.pop_emit = 1'b1;
          cnt_next     = cnt + CNT_W'(1);
          state_next   = S_LOOP;
        end
      end
      S_FLUSH: begin
        if (!st.pend_v) begin
          state_next = S_IDLE;
        end else if (st.emit_ok) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `GLZW_ASSERT_SAME(a_idle_no_pend, state == S_IDLE, !st.pend_v, "held result left at idle")
  `GLZW_ASSERT_NEXT(a_accept_loop, data_valid && !data_stall, state == S_LOOP, "accept lost")
  `GLZW_ASSERT_SAME(a_pop_nz, state == S_POP, st.stack_nz, "pop from empty stack")
  `GLZW_ASSERT_SAME(a_cnt_cap, 1'b1, cnt <= RES_MAX, "result count above cap")

endmodule

// File: design/glzw_dp.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder datapath
// Configuration, bit unpacking, code tables, string stack, pixel position
// tracking and the held/output result registers.
// ----------------------------------------------------------------------------
module glzw_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          data_byte,
  input  logic                start_image,
  input  logic                result_stall,
  output logic                result_valid,
  output logic [7:0]          pixel,
  output logic [15:0]         row,
  output logic [15:0]         column,
  output logic                last,
  output logic                image_done,
  output logic                bad_code,
  input  glzw_pkg::ctl_cmd_t  cmd,
  output glzw_pkg::dp_stat_t  st
);
  import glzw_pkg::*;

  // Configuration registers.
  logic [3:0]  min_code_size;
  logic [15:0] line_width;
  logic [15:0] image_height;
  logic        interlaced;

  // Decoder state.
  logic [TAB_AW-1:0]   old_code, wcode, cur_code;
  logic [SYM_W-1:0]    first_char;
  logic [DEPTH_W-1:0]  next_slot, slot_limit, depth;
  logic [3:0]          code_width;
  logic [ACC_BITS-1:0] acc;
  logic [HELD_W-1:0]   held;
  logic [7:0]          bbl;
  logic [15:0]         col_cnt, rows_done;
  logic                finished, first_code, bad_flag;

  // Held result waiting to learn whether it ends the beat.
  logic        pend_v;
  logic [7:0]  pend_pixel;
  logic [15:0] pend_row, pend_col;
  logic        pend_done, pend_bad;

  // Code decode terms.
  logic [3:0]         s_eff;
  logic [TAB_AW-1:0]  clr, endc, fresh, mask, c, fc_val;
  logic [3:0]         rs_cw;
  logic [DEPTH_W-1:0] rs_limit, rs_ns, ns_new, depth_m1;
  logic               c_ge_ns, fc_bad;

  assign s_eff    = eff_size(min_code_size);
  assign clr      = TAB_AW'(1) << s_eff;
  assign endc     = clr + TAB_AW'(1);
  assign fresh    = clr + TAB_AW'(2);
  assign mask     = TAB_AW'((13'd1 << code_width) - 13'd1);
  assign c        = acc[TAB_AW-1:0] & mask;
  assign c_ge_ns  = {1'b0, c} >= next_slot;
  assign fc_bad   = c_ge_ns;
  assign fc_val   = fc_bad ? '0 : c;
  assign rs_cw    = s_eff + 4'd1;
  assign rs_limit = DEPTH_W'(1) << rs_cw;
  assign rs_ns    = {1'b0, fresh};
  assign depth_m1 = depth - DEPTH_W'(1);

  // Tables and stack ports.
  logic                  tw_en;
  logic [20:0]           tab_rd;
  logic                  push_req, push_en;
  logic [SYM_W-1:0]      push_val, stk_rd;

  assign tw_en  = cmd.walk_end && (next_slot < slot_limit) &&
                  (next_slot < DEPTH_W'(TABLE_ENTRIES));
  assign ns_new = next_slot + DEPTH_W'(tw_en);

  assign push_req = (cmd.dec && !st.is_clr && !st.is_end && (first_code || c_ge_ns)) ||
                    cmd.walk_push || cmd.walk_end;
  assign push_en  = push_req && (depth < DEPTH_W'(TABLE_ENTRIES));

  always_comb begin
    if (cmd.walk_push) begin
      push_val = tab_rd[SYM_W-1:0];
    end else if (cmd.walk_end) begin
      push_val = wcode[SYM_W-1:0];
    end else if (first_code) begin
      push_val = fc_val[SYM_W-1:0];
    end else begin
      push_val = first_char;
    end
  end

  glzw_ram #(.WIDTH(TAB_AW + SYM_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .wr_en   (tw_en),
    .wr_addr (next_slot[TAB_AW-1:0]),
    .wr_data ({old_code, wcode[SYM_W-1:0]}),
    .rd_en   (cmd.walk_rd),
    .rd_addr (wcode),
    .rd_data (tab_rd)
  );

  glzw_ram #(.WIDTH(SYM_W), .DEPTH(TABLE_ENTRIES)) u_stack (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (depth[TAB_AW-1:0]),
    .wr_data (push_val),
    .rd_en   (cmd.pop_rd),
    .rd_addr (depth_m1[TAB_AW-1:0]),
    .rd_data (stk_rd)
  );

  // Pixel position: column wrap, row count and interlace row mapping.
  logic [16:0] w_eff, h_eff, col_inc, rows_inc, n1, n2, n3, b2, b3, lrow, mrow;
  logic        row_wrap, img_end;

  assign w_eff    = (line_width == 16'd0) ? 17'h10000 : {1'b0, line_width};
  assign h_eff    = (image_height == 16'd0) ? 17'h10000 : {1'b0, image_height};
  assign col_inc  = {1'b0, col_cnt} + 17'd1;
  assign rows_inc = {1'b0, rows_done} + 17'd1;
  assign row_wrap = col_inc >= w_eff;
  assign img_end  = row_wrap && (rows_inc >= h_eff);
  assign n1       = (h_eff + 17'd7) >> 3;
  assign n2       = (h_eff + 17'd3) >> 3;
  assign n3       = (h_eff + 17'd1) >> 2;
  assign b2       = n1 + n2;
  assign b3       = b2 + n3;
  assign lrow     = {1'b0, rows_done};

  always_comb begin
    if (!interlaced) begin
      mrow = lrow;
    end else if (lrow < n1) begin
      mrow = lrow << 3;
    end else if (lrow < b2) begin
      mrow = ((lrow - n1) << 3) + 17'd4;
    end else if (lrow < b3) begin
      mrow = ((lrow - b2) << 2) + 17'd2;
    end else begin
      mrow = ((lrow - b3) << 1) + 17'd1;
    end
  end

  // Byte intake terms.
  logic       fin_eff, bbl_zero, emit_now, out_free, zero_depth, out_load;
  logic [5:0] held_room;

  assign fin_eff   = start_image ? 1'b0 : finished;
  assign bbl_zero  = start_image || (bbl == 8'd0);
  assign held_room = {1'b0, held} + 6'd8;
  assign out_free  = !result_valid || !result_stall;

  // Status to the controller.
  assign st.finished   = finished;
  assign st.stack_nz   = (depth != '0);
  assign st.bits_ok    = (held >= {1'b0, code_width});
  assign st.is_clr     = (c == clr);
  assign st.is_end     = (c == endc);
  assign st.is_first   = first_code;
  assign st.walk_more  = (wcode >= fresh) && (depth < DEPTH_W'(TABLE_ENTRIES));
  assign st.emit_ok    = !pend_v || out_free;
  assign st.pend_v     = pend_v;
  assign st.acc_status = !fin_eff && bbl_zero && (data_byte == 8'd0);

  assign emit_now   = (cmd.accept && st.acc_status) || (cmd.dec && st.is_end) ||
                      cmd.pop_emit;
  assign zero_depth = (cmd.accept && (start_image || st.acc_status)) ||
                      (cmd.dec && st.is_end) || (cmd.pop_emit && img_end);
  assign out_load   = (emit_now && pend_v) || cmd.flush;

  // Configuration and decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_size <= MIN_SIZE_RST;
      line_width    <= 16'd1;
      image_height  <= 16'd1;
      interlaced    <= 1'b0;
      code_width    <= eff_size(MIN_SIZE_RST) + 4'd1;
      slot_limit    <= DEPTH_W'(1) << (eff_size(MIN_SIZE_RST) + 4'd1);
      next_slot     <= (DEPTH_W'(1) << eff_size(MIN_SIZE_RST)) + DEPTH_W'(2);
      first_code    <= 1'b1;
      old_code      <= '0;
      first_char    <= '0;
      acc           <= '0;
      held          <= '0;
      bbl           <= '0;
      col_cnt       <= '0;
      rows_done     <= '0;
      finished      <= 1'b0;
      bad_flag      <= 1'b0;
      depth         <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_SIZE:  min_code_size <= cfg_data[3:0];
          REG_WIDTH:     line_width    <= cfg_data;
          REG_HEIGHT:    image_height  <= cfg_data;
          REG_INTERLACE: interlaced    <= cfg_data[0];
          default:       interlaced    <= interlaced;
        endcase
      end

      // Input beat: optional restart, then length or data byte. A restart
      // always lands in the length-byte branch, which sets the block count
      // and the finished flag.
      if (cmd.accept) begin
        if (start_image) begin
          code_width <= rs_cw;
          slot_limit <= rs_limit;
          next_slot  <= rs_ns;
          first_code <= 1'b1;
          old_code   <= '0;
          first_char <= '0;
          acc        <= '0;
          held       <= '0;
          col_cnt    <= '0;
          rows_done  <= '0;
          bad_flag   <= 1'b0;
        end
        if (!fin_eff) begin
          if (bbl_zero) begin
            bbl      <= data_byte;
            finished <= (data_byte == 8'd0);
          end else begin
            bbl <= bbl - 8'd1;
            if (held_room <= 6'(ACC_BITS)) begin
              acc  <= acc | (ACC_BITS'(data_byte) << held);
              held <= held_room[HELD_W-1:0];
            end
          end
        end
      end

      // One code taken from the accumulator.
      if (cmd.dec) begin
        acc  <= acc >> code_width;
        held <= held - {1'b0, code_width};
        if (st.is_clr) begin
          code_width <= rs_cw;
          slot_limit <= rs_limit;
          next_slot  <= rs_ns;
          first_code <= 1'b1;
        end else if (st.is_end) begin
          finished <= 1'b1;
        end else if (first_code) begin
          first_code <= 1'b0;
          if (fc_bad) begin
            bad_flag <= 1'b1;
          end
          old_code   <= fc_val;
          first_char <= fc_val[SYM_W-1:0];
        end else begin
          if ({1'b0, c} > next_slot) begin
            bad_flag <= 1'b1;
          end
          wcode    <= c_ge_ns ? old_code : c;
          cur_code <= c;
        end
      end

      // Chain walk step and chain end with the new table entry.
      if (cmd.walk_push) begin
        wcode <= tab_rd[TAB_AW+SYM_W-1:SYM_W];
      end
      if (cmd.walk_end) begin
        next_slot  <= ns_new;
        first_char <= wcode[SYM_W-1:0];
        old_code   <= cur_code;
        if (ns_new >= slot_limit && code_width < 4'(MAX_CODE_BITS)) begin
          slot_limit <= slot_limit << 1;
          code_width <= code_width + 4'd1;
        end
      end

      // Pixel position after a pop.
      if (cmd.pop_emit) begin
        if (row_wrap) begin
          col_cnt   <= '0;
          rows_done <= rows_inc[15:0];
          if (img_end) begin
            finished <= 1'b1;
          end
        end else begin
          col_cnt <= col_inc[15:0];
        end
      end

      // Stack depth.
      if (zero_depth) begin
        depth <= '0;
      end else if (push_en) begin
        depth <= depth + DEPTH_W'(1);
      end else if (cmd.pop_emit) begin
        depth <= depth_m1;
      end
    end
  end

  // Held result and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (emit_now) begin
        if (pend_v) begin
          pixel        <= pend_pixel;
          row          <= pend_row;
          column       <= pend_col;
          image_done   <= pend_done;
          bad_code     <= pend_bad;
          last         <= 1'b0;
        end
        pend_v     <= 1'b1;
        // A restart clears the sticky flag before its status result.
        pend_bad   <= (cmd.accept && start_image) ? 1'b0 : bad_flag;
        if (cmd.pop_emit) begin
          pend_pixel <= stk_rd[7:0];
          pend_row   <= mrow[15:0];
          pend_col   <= col_cnt;
          pend_done  <= img_end;
        end else begin
          pend_pixel <= '0;
          pend_row   <= '0;
          pend_col   <= '0;
          pend_done  <= 1'b1;
        end
      end else if (cmd.flush) begin
        pixel        <= pend_pixel;
        row          <= pend_row;
        column       <= pend_col;
        image_done   <= pend_done;
        bad_code     <= pend_bad;
        last         <= 1'b1;
        pend_v       <= 1'b0;
      end
    end
  end

endmodule

// File: design/gif_lzw_decoder.sv
// A byte without codes passes through intake, the code loop and the flush. A
// clear or first code adds a decode step, any other code a decode and a chain
// end, each chain link a table read and a push, and each pixel a stack read
// and an emit, since the table and stack reads are registered. Up to 64
// results per byte; the rest follow on later bytes. A popped pixel is held
// until the next result or the flush, to mark the last result of the beat.
// ----------------------------------------------------------------------------
// GIF LZW decoder
// Strips sub-block lengths, unpacks variable-width codes and expands them into
// pixels with their column and interlace-mapped row. Reset (rst, synchronous)
// restores configuration defaults and decoder state.
// ----------------------------------------------------------------------------
module gif_lzw_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_image,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  pixel,
  output logic [15:0] row,
  output logic [15:0] column,
  output logic        last,
  output logic        image_done,
  output logic        bad_code
);
  import glzw_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  glzw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .st         (st),
    .cmd        (cmd)
  );

  glzw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .start_image  (start_image),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .pixel        (pixel),
    .row          (row),
    .column       (column),
    .last         (last),
    .image_done   (image_done),
    .bad_code     (bad_code),
    .cmd          (cmd),
    .st           (st)
  );

endmodule
